>>> rtl/cfln_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfln_pkg - shared constants and types
// Widths, limits and status codes for the continued fraction log core.
// ----------------------------------------------------------------------------
package cfln_pkg;

	localparam int XW        = 32;
	localparam int LW        = 32;
	localparam int TW        = 7;
	localparam int FRAC_BITS = 30;
	localparam int MAX_TERMS = 64;
	localparam int CFW       = 43;  // signed cf, |cf| <= 2^40, magnitude 41 bits
	localparam int MW        = 72;  // numerator magnitude width (a*z2 < 2^12*2^31)
	localparam int DW        = 44;  // denominator magnitude width
	localparam int QW        = 41;  // quotient magnitude width
	localparam int QSTEPS    = QW;  // equal to QW; not used by the divider

	localparam logic [TW-1:0] TERM_RESET = TW'(8);
	localparam logic [QW-1:0] CF_LIMIT   = QW'(1) << 40;

	typedef enum logic [1:0] {
		ST_VALID = 2'd0,
		ST_ZERO  = 2'd1,
		ST_NEG   = 2'd2
	} status_t;

	typedef struct packed {
		logic          start;
		logic [MW-1:0] num;
		logic          num_neg;
		logic [DW-1:0] den;
		logic          den_neg;
		logic          shift;
	} div_req_t;

	typedef struct packed {
		logic           done;
		logic [QW-1:0]  qmag;
		logic           neg;
	} div_rsp_t;

endpackage

>>> rtl/cfln_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfln_div - bit-serial fractional divider
// Restoring divide, one quotient bit per cycle; q = n*2^30/d (or n/d when
// shift is clear), truncated, saturated to 2^40, signs applied by caller.
// ----------------------------------------------------------------------------
module cfln_div (
	input  logic                clk,
	input  logic                arst_n,
	input  cfln_pkg::div_req_t  req,
	output cfln_pkg::div_rsp_t  rsp
);

	localparam int RW  = cfln_pkg::DW + 1;
	localparam int NSW = cfln_pkg::MW + cfln_pkg::FRAC_BITS;
	localparam int CW  = $clog2(NSW + 1);

	logic [NSW-1:0]           n_q;
	logic [RW-1:0]            r_q;
	logic [cfln_pkg::DW-1:0]  d_q;
	logic [cfln_pkg::QW:0]    q_q;
	logic [CW-1:0]            cnt_q;
	logic                     busy_q, neg_q, done_q, zero_q, sat_q;

	logic [RW-1:0] r_sh, r_sub;
	logic          ge;

	always_comb begin
		r_sh  = {r_q[RW-2:0], n_q[NSW-1]};
		ge    = r_sh >= RW'(d_q);
		r_sub = ge ? r_sh - RW'(d_q) : r_sh;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(NSW);
			end else if (busy_q) begin
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			n_q    <= req.shift ? {req.num, {cfln_pkg::FRAC_BITS{1'b0}}}
				: NSW'(req.num);
			d_q    <= req.den;
			r_q    <= '0;
			q_q    <= '0;
			sat_q  <= 1'b0;
			zero_q <= (req.num == '0);
			neg_q  <= (req.den == '0) ? req.num_neg : (req.num_neg ^ req.den_neg);
		end else if (busy_q) begin
			n_q <= {n_q[NSW-2:0], 1'b0};
			r_q <= r_sub;
			q_q <= {q_q[cfln_pkg::QW-1:0], ge};
			if (q_q[cfln_pkg::QW]) sat_q <= 1'b1;
		end
	end

	logic over;
	assign over = sat_q || q_q[cfln_pkg::QW] || (d_q == '0)
		|| (q_q[cfln_pkg::QW-1:0] > cfln_pkg::CF_LIMIT);

	assign rsp.done = done_q;
	assign rsp.qmag = zero_q ? '0 : (over ? cfln_pkg::CF_LIMIT : q_q[cfln_pkg::QW-1:0]);
	assign rsp.neg  = neg_q && !zero_q;

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(busy_q)) else $error("done without busy");
	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && cnt_q > CW'(1) |=> busy_q) else $error("divider dropped busy");
	a_cnt_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!busy_q && !req.start |=> !busy_q) else $error("spurious busy");

endmodule

>>> rtl/continued_fraction_natural_log_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// continued_fraction_natural_log_core - ln(x) by truncated continued fraction
// Q16.16 in, Q7.24 out with status; one operand in flight at a time.
// ----------------------------------------------------------------------------
// One operand is processed at a time. Zero or negative operands skip the
// divider and go straight to S_DONE. Otherwise, with n being term_count
// clipped to 64, the shared bit-serial divider first computes z, then a
// shift-add forms z^2 one bit of zm at a time; each term k > 1 takes a
// shift-add a*z^2 over the 12 bits of a and a divide, and the last term a
// divide only (for n = 0 no term is computed). After the result is loaded
// the core passes through S_OUT back to S_IDLE, where the next operand is
// accepted. The result register frees the input side as soon as the
// result is loaded; a finished operand waits in place only while the
// previous result is unread.
module continued_fraction_natural_log_core (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [cfln_pkg::TW-1:0]           cfg_data,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic signed [cfln_pkg::XW-1:0]    x_value,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic signed [cfln_pkg::LW-1:0]    log_value,
	output logic [1:0]                        status
);

	typedef enum logic [7:0] {
		S_IDLE = 8'b0000_0001,
		S_ZDIV = 8'b0000_0010,
		S_Z2   = 8'b0000_0100,
		S_MUL  = 8'b0000_1000,
		S_TDIV = 8'b0001_0000,
		S_TWAIT= 8'b0010_0000,
		S_DONE = 8'b0100_0000,
		S_OUT  = 8'b1000_0000
	} state_t;

	localparam int KW = cfln_pkg::TW;
	localparam int ZW = 31;
	localparam int AW = 12;

	state_t                     state_q;
	logic [cfln_pkg::TW-1:0]    term_q;
	logic [KW-1:0]              k_q;
	logic [ZW-1:0]              zm_q;
	logic                       zneg_q;
	logic [ZW:0]                z2_q;
	logic [cfln_pkg::QW-1:0]    cfm_q;
	logic                       cfneg_q;
	logic [cfln_pkg::MW-1:0]    prod_q;
	logic [AW-1:0]              a_q;
	logic [3:0]                 mcnt_q;
	logic [61:0]                zz_q;
	logic [5:0]                 zcnt_q;
	logic                       res_valid_q;
	logic [cfln_pkg::LW-1:0]    res_q;
	logic [1:0]                 stat_q;
	logic [1:0]                 ostat_q;
	logic                       res_load;

	cfln_pkg::div_req_t req;
	cfln_pkg::div_rsp_t rsp;

	cfln_div u_div (.clk(clk), .arst_n(arst_n), .req(req), .rsp(rsp));

	assign cfg_ready = (state_q == S_IDLE) && !res_valid_q;
	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = res_valid_q;
	assign log_value = res_q;
	assign status    = ostat_q;
	assign res_load  = (state_q == S_DONE) && (!res_valid_q || out_ready);

	logic [KW-1:0] n_clip;
	assign n_clip = (cfg_data > KW'(cfln_pkg::MAX_TERMS)) ? KW'(cfln_pkg::MAX_TERMS) : '0;

	// signed denominator: b*2^30 - cf (k>1) or 2^30 - cf (k=1)
	logic [KW:0]                     b_val;
	logic signed [cfln_pkg::DW:0]    den_s;
	logic signed [cfln_pkg::DW:0]    cf_s;
	always_comb begin
		b_val = (k_q == KW'(1)) ? (KW+1)'(1) : {k_q, 1'b0} - (KW+1)'(1);
		cf_s  = cfneg_q ? -$signed({4'b0, cfm_q}) : $signed({4'b0, cfm_q});
		den_s = $signed((cfln_pkg::DW+1)'({b_val, {cfln_pkg::FRAC_BITS{1'b0}}})) - cf_s;
	end

	logic [cfln_pkg::XW:0] xnum_m;
	assign xnum_m = (x_value >= 32'sd65536) ? 33'(x_value) - 33'd65536
		: 33'd65536 - 33'(x_value);

	always_comb begin
		req = '0;
		unique case (state_q)
			S_IDLE: begin
				req.start   = in_valid && in_ready && x_value > 0;
				req.num     = cfln_pkg::MW'(xnum_m);
				req.den     = cfln_pkg::DW'(33'(x_value) + 33'd65536);
				req.shift   = 1'b1;
			end
			S_TDIV: begin
				req.start   = 1'b1;
				req.num     = (k_q == KW'(1)) ? cfln_pkg::MW'({zm_q, 1'b0}) : prod_q;
				req.num_neg = (k_q == KW'(1)) && zneg_q;
				req.den     = den_s[cfln_pkg::DW] ? cfln_pkg::DW'(-den_s)
					: cfln_pkg::DW'(den_s);
				req.den_neg = den_s[cfln_pkg::DW];
				req.shift   = 1'b1;
			end
			default: ;
		endcase
	end

	// rounding of cf to Q24
	logic [cfln_pkg::QW-1:0] rnd;
	logic [cfln_pkg::LW-1:0] res_fin;
	always_comb begin
		rnd = (cfm_q + cfln_pkg::QW'(32)) >> 6;
		if (cfneg_q)
			res_fin = (rnd > cfln_pkg::QW'(33'h80000000)) ? 32'h80000000
				: 32'(-rnd);
		else
			res_fin = (rnd > cfln_pkg::QW'(32'h7FFFFFFF)) ? 32'h7FFFFFFF : 32'(rnd);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			term_q      <= cfln_pkg::TERM_RESET;
			res_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) term_q <= cfg_data;
			if (res_load) res_valid_q <= 1'b1;
			else if (out_valid && out_ready) res_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: if (in_valid && in_ready) begin
					if (x_value > 0) state_q <= S_ZDIV;
					else state_q <= S_DONE;
				end
				S_ZDIV: if (rsp.done) state_q <= S_Z2;
				S_Z2: if (zcnt_q == 6'd0) begin
					state_q <= (k_q == '0) ? S_DONE
						: (k_q == KW'(1)) ? S_TDIV : S_MUL;
				end
				S_MUL: if (mcnt_q == 4'd0) state_q <= S_TDIV;
				S_TDIV: state_q <= S_TWAIT;
				S_TWAIT: if (rsp.done) begin
					if (k_q == KW'(1)) state_q <= S_DONE;
					else state_q <= (k_q == KW'(2)) ? S_TDIV : S_MUL;
				end
				S_DONE: if (res_load) state_q <= S_OUT;
				S_OUT: state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	logic [KW-1:0] km1;
	assign km1 = k_q - KW'(1);

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: if (in_valid && in_ready) begin
				stat_q  <= (x_value == 0) ? cfln_pkg::ST_ZERO
					: (x_value < 0) ? cfln_pkg::ST_NEG : cfln_pkg::ST_VALID;
				zneg_q  <= x_value < 32'sd65536;
				k_q     <= (term_q > KW'(cfln_pkg::MAX_TERMS)) ? n_clip | KW'(cfln_pkg::MAX_TERMS)
					: term_q;
				cfm_q   <= '0;
				cfneg_q <= 1'b0;
			end
			S_ZDIV: if (rsp.done) begin
				zm_q   <= ZW'(rsp.qmag);
				zz_q   <= '0;
				zcnt_q <= 6'd31;
				a_q    <= '0;
			end
			S_Z2: begin
				// shift-add square, one bit of zm per cycle (MSB first)
				if (zcnt_q != 6'd0) begin
					zz_q   <= (zz_q << 1) + (zm_q[zcnt_q[4:0] - 5'd1] ? 62'(zm_q) : 62'd0);
					zcnt_q <= zcnt_q - 6'd1;
				end else begin
					z2_q   <= (ZW+1)'(zz_q >> cfln_pkg::FRAC_BITS);
					a_q    <= AW'(km1) * AW'(km1);
					prod_q <= '0;
					mcnt_q <= 4'd12;
				end
			end
			S_MUL: begin
				if (mcnt_q != 4'd0) begin
					prod_q <= (prod_q << 1)
						+ (a_q[mcnt_q - 4'd1] ? cfln_pkg::MW'(z2_q) : '0);
					mcnt_q <= mcnt_q - 4'd1;
				end
			end
			S_TWAIT: if (rsp.done) begin
				cfm_q   <= rsp.qmag;
				cfneg_q <= rsp.neg;
				k_q     <= km1;
				a_q     <= AW'(km1 - KW'(1)) * AW'(km1 - KW'(1));
				prod_q  <= '0;
				mcnt_q  <= 4'd12;
			end
			S_DONE: if (res_load) begin
				// cf stays zero for zero and negative operands
				res_q   <= res_fin;
				ostat_q <= stat_q;
			end
			default: ;
		endcase
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(res_q)) else $error("result lost");
	a_busy_no_in: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != S_IDLE |-> !in_ready) else $error("accept while busy");
	a_cfg_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_ready |-> state_q == S_IDLE) else $error("config while busy");

endmodule

>>> sim/tb_continued_fraction_natural_log_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_continued_fraction_natural_log_core - self-checking bench for the ln core
// Drives Q16.16 operands through valid/ready, predicts each Q7.24 log and its
// status in a scoreboard, and walks term_count through several settings.
// ----------------------------------------------------------------------------
module tb_continued_fraction_natural_log_core;

	typedef struct {
		logic signed [cfln_pkg::LW-1:0] log_value;
		cfln_pkg::status_t              status;
	} log_beat_t;

	class log_scoreboard;
		int unsigned      term_count = cfln_pkg::TERM_RESET;
		log_beat_t        pending_q[$];
		int               errors = 0;
		int               checked = 0;

		function longint unsigned mag(longint v);
			return v < 0 ? 64'(-v) : 64'(v);
		endfunction

		// n * 2^30 / d, truncated, clamped to +-2^40
		function longint q30_div(longint n, longint d);
			longint unsigned un, ud, q, r;
			bit neg;
			un = mag(n);
			ud = mag(d);
			neg = (n < 0) != (d < 0);
			if (un == 0)
				return 0;
			if (ud == 0) begin
				q = 64'd1 << 40;
				neg = n < 0;
			end else if (un / ud >= 64'd1024) begin
				q = 64'd1 << 40;
			end else begin
				q = un / ud;
				r = un % ud;
				for (int i = 0; i < cfln_pkg::FRAC_BITS; i++) begin
					r = r << 1;
					q = q << 1;
					if (r >= ud) begin
						r = r - ud;
						q = q | 1;
					end
				end
				if (q > (64'd1 << 40))
					q = 64'd1 << 40;
			end
			return neg ? -longint'(q) : longint'(q);
		endfunction

		function log_beat_t ln_of(logic signed [cfln_pkg::XW-1:0] x);
			log_beat_t e;
			longint xs, num, den, z, z2, cf, a, b;
			longint unsigned zm, m;
			int n;
			xs = x;
			e.log_value = '0;
			e.status = cfln_pkg::ST_VALID;
			if (xs == 0) begin
				e.status = cfln_pkg::ST_ZERO;
				return e;
			end
			if (xs < 0) begin
				e.status = cfln_pkg::ST_NEG;
				return e;
			end
			num = xs - 65536;
			den = xs + 65536;
			zm = (mag(num) << cfln_pkg::FRAC_BITS) / 64'(den);
			z = num < 0 ? -longint'(zm) : longint'(zm);
			z2 = longint'((zm * zm) >> cfln_pkg::FRAC_BITS);
			n = term_count > cfln_pkg::MAX_TERMS ? cfln_pkg::MAX_TERMS : term_count;
			cf = 0;
			for (int k = n; k >= 1; k--) begin
				if (k == 1) begin
					cf = q30_div(2 * z, (longint'(1) << cfln_pkg::FRAC_BITS) - cf);
				end else begin
					a = (k - 1) * (k - 1);
					b = 2 * k - 1;
					cf = q30_div(a * z2, (b << cfln_pkg::FRAC_BITS) - cf);
				end
			end
			m = (mag(cf) + 32) >> 6;
			if (cf < 0) begin
				if (m > 64'h8000_0000)
					m = 64'h8000_0000;
				e.log_value = cfln_pkg::LW'(-longint'(m));
			end else begin
				if (m > 64'h7FFF_FFFF)
					m = 64'h7FFF_FFFF;
				e.log_value = cfln_pkg::LW'(m);
			end
			return e;
		endfunction

		function void note_operand(logic signed [cfln_pkg::XW-1:0] x);
			pending_q.push_back(ln_of(x));
		endfunction

		function void check_result(logic signed [cfln_pkg::LW-1:0] lv, logic [1:0] st);
			log_beat_t e;
			if (pending_q.size() == 0) begin
				$error("unexpected result beat: log_value %0d status %0d", lv, st);
				errors++;
				return;
			end
			e = pending_q.pop_front();
			checked++;
			if (lv !== e.log_value) begin
				$error("log_value: expected %0d actual %0d", e.log_value, lv);
				errors++;
			end
			if (st !== e.status) begin
				$error("status: expected %0d actual %0d", e.status, st);
				errors++;
			end
		endfunction
	endclass

	logic                           clk = 1'b0;
	logic                           arst_n = 1'b0;
	logic                           cfg_valid = 1'b0;
	logic                           cfg_ready;
	logic [cfln_pkg::TW-1:0]        cfg_data = '0;
	logic                           in_valid = 1'b0;
	logic                           in_ready;
	logic signed [cfln_pkg::XW-1:0] x_value = '0;
	logic                           out_valid;
	logic                           out_ready = 1'b0;
	logic signed [cfln_pkg::LW-1:0] log_value;
	logic [1:0]                     status;

	log_scoreboard sb = new();
	bit            no_gaps = 1'b0;
	bit            hold_req = 1'b0;
	int            sent = 0;

	continued_fraction_natural_log_core i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.x_value   (x_value),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.log_value (log_value),
		.status    (status)
	);

	always #5 clk = ~clk;

	initial begin
		#50_000_000;
		$display("tb_continued_fraction_natural_log_core NOT OK");
		$finish;
	end

	function int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (no_gaps || r < 50)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	function logic [cfln_pkg::XW-1:0] rand_operand();
		int r;
		r = $urandom_range(0, 99);
		if (r < 65)
			return $urandom >> $urandom_range(1, 31);
		if (r < 75)
			return 32'h0001_0000 + $urandom_range(0, 4096) - 2048;
		if (r < 85)
			return $urandom | 32'h8000_0000;
		if (r < 90)
			return '0;
		return $urandom;
	endfunction

	task send_operand(logic [cfln_pkg::XW-1:0] x);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		x_value <= x;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		sb.note_operand(x);
		sent++;
	endtask

	task write_terms(logic [cfln_pkg::TW-1:0] v);
		in_valid <= 1'b0;
		while (sb.pending_q.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		sb.term_count = 32'(v);
	endtask

	// result side: random stalls plus one long hold-off on request
	initial begin
		int stall;
		int r;
		stall = 0;
		forever begin
			@(posedge clk);
			if (out_valid && out_ready)
				sb.check_result(log_value, status);
			if (stall > 0) begin
				stall--;
				out_ready <= 1'b0;
			end else if (hold_req) begin
				hold_req = 1'b0;
				stall = 600;
				out_ready <= 1'b0;
			end else begin
				r = $urandom_range(0, 99);
				if (no_gaps || r < 70) begin
					out_ready <= 1'b1;
				end else begin
					out_ready <= 1'b0;
					stall = r < 96 ? $urandom_range(0, 3) : $urandom_range(20, 80);
				end
			end
		end
	end

	initial begin
		logic [cfln_pkg::XW-1:0] directed[$];
		int unsigned             tc_list[$];
		int                      cnt_list[$];
		int                      waited;
		directed = '{32'h0001_0000, 32'h0000_0001, 32'h7FFF_FFFF, 32'h8000_0000,
			32'h0000_0000, 32'hFFFF_FFFF, 32'h0001_0001, 32'h0000_FFFF,
			32'd178145, 32'h0002_0000, 32'h4000_0000, 32'h0000_8000,
			32'h5555_5555, 32'h2AAA_AAAA, 32'hAAAA_AAAA, 32'h0000_000A,
			32'h0064_0000, 32'h0000_0100};
		tc_list = '{0, 1, 2, 3, 64, 127, 12, 5, 8};
		cnt_list = '{110, 150, 150, 140, 8, 6, 90, 110, 30};

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		foreach (directed[i])
			send_operand(directed[i]);

		foreach (tc_list[p]) begin
			write_terms(cfln_pkg::TW'(tc_list[p]));
			if (p == 0)
				hold_req = 1'b1;
			for (int i = 0; i < cnt_list[p]; i++) begin
				no_gaps = (i >= 20 && i < 40);
				send_operand(rand_operand());
			end
			no_gaps = 1'b0;
		end
		in_valid <= 1'b0;

		waited = 0;
		while (sb.pending_q.size() != 0 && waited < 200000) begin
			@(posedge clk);
			waited++;
		end
		if (sb.pending_q.size() != 0) begin
			$display("tb_continued_fraction_natural_log_core NOT OK");
			$finish;
		end
		repeat (50) @(posedge clk);

		$display("Covered %0d operands, %0d results checked, term counts 8,0,1,2,3,64,127,12,5,8",
			sent, sb.checked);
		if (sb.errors == 0 && sb.pending_q.size() == 0)
			$display("tb_continued_fraction_natural_log_core OK");
		else
			$display("tb_continued_fraction_natural_log_core NOT OK");
		$finish;
	end

endmodule
